/* rtl/core/tsbhm_pkg.sv */
// shared types and constants for the two-slot bucket hash map
package tsbhm_pkg;

    localparam int KEY_W      = 64;
    localparam int KEY_LEN_W  = 4;
    localparam int VALUE_W    = 32;
    localparam int SIZE_W     = 5;
    localparam int BYTE_W     = 8;
    localparam int MAX_BYTES  = KEY_W / BYTE_W;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(10);

    localparam logic CMD_READ    = 1'b0;
    localparam logic CMD_WRITE   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                        command;
        logic [KEY_W-1:0]            key;
        logic [KEY_LEN_W-1:0]        key_len;
        logic signed [VALUE_W-1:0]   write_value;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0]   read_value;
        logic                        inserted;
        logic                        status;
    } t_resp;

    typedef struct packed {
        logic [KEY_W-1:0]            key;
        logic [KEY_LEN_W-1:0]        key_len;
        logic [VALUE_W-1:0]          value;
    } t_slot;

    // one bucket: slot 1 in the upper half, slot 0 in the lower half
    typedef struct packed {
        t_slot s1;
        t_slot s0;
    } t_row;

endpackage

/* rtl/core/two_slot_bucket_hash_map.sv */
// top level of the two-slot bucket hash map: sequencer, bucket memory, output register
//
//   channel | handshake                     | payload
//   --------+-------------------------------+---------------------------
//   request | i_in_valid / o_in_ready       | i_in  (tsbhm_pkg::t_req)
//   result  | o_out_valid / i_out_ready     | o_out (tsbhm_pkg::t_resp)
//   config  | i_cfg_valid / o_cfg_ready     | i_cfg_data (table_size)
//
// a request runs the bit-serial remainder unit (one bit per cycle) on the first key
// byte, then a registered bucket memory read and a check; a second bucket reruns the
// remainder unit on the last key byte, each later bucket steps to the next index.
// after reset the valid bits are cleared one bucket per cycle, with o_in_ready low;
// config writes are taken only in idle, ahead of a request.
// one request is worked at a time; the next may be taken while a result waits.
module two_slot_bucket_hash_map #(
    parameter int BUCKETS   = 16,
    parameter int KEY_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tsbhm_pkg::t_req                   i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tsbhm_pkg::t_resp                  o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tsbhm_pkg::SIZE_W-1:0]      i_cfg_data
);

    localparam int BW       = $clog2(BUCKETS);
    localparam int CW       = ((BW > tsbhm_pkg::SIZE_W) ? BW : tsbhm_pkg::SIZE_W) + 1;
    localparam int MAX_SIZE = (BUCKETS < 31) ? BUCKETS : 31;
    localparam int PW       = tsbhm_pkg::SIZE_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state                              r_state;
    logic [BW-1:0]                       r_clr;
    logic [BW-1:0]                       r_idx;
    logic [PW-1:0]                       r_probes;
    logic [tsbhm_pkg::SIZE_W-1:0]        r_table_size;
    logic                                r_cmd;
    logic [tsbhm_pkg::KEY_W-1:0]         r_key;
    logic [tsbhm_pkg::KEY_LEN_W-1:0]     r_len;
    logic [tsbhm_pkg::VALUE_W-1:0]       r_wval;
    logic [tsbhm_pkg::BYTE_W-1:0]        r_last_byte;
    logic                                r_mod_start;
    logic [tsbhm_pkg::BYTE_W-1:0]        r_mod_byte;
    tsbhm_pkg::t_resp                    r_res;
    tsbhm_pkg::t_resp                    r_out;
    logic                                r_out_valid;

    logic [1:0]                          r_vmem [BUCKETS];
    tsbhm_pkg::t_row                     r_dmem [BUCKETS];
    logic [1:0]                          r_vq;
    tsbhm_pkg::t_row                     r_row_q;

    logic [tsbhm_pkg::SIZE_W-1:0]        size;
    logic                                mod_done;
    logic [tsbhm_pkg::SIZE_W-1:0]        mod_rem;

    logic [tsbhm_pkg::KEY_LEN_W-1:0]     in_len;
    logic [tsbhm_pkg::KEY_W-1:0]         in_key;
    logic [tsbhm_pkg::BYTE_W-1:0]        in_last;

    logic                                hit0;
    logic                                hit1;
    logic                                found;
    logic                                sel1;
    logic                                ins;
    logic [tsbhm_pkg::VALUE_W-1:0]       new_val;
    tsbhm_pkg::t_slot                    new_slot;
    tsbhm_pkg::t_row                     new_row;
    logic [1:0]                          new_vld;
    logic [PW-1:0]                       probes_nxt;
    logic [BW-1:0]                       idx_inc;

    logic                                vm_we;
    logic [BW-1:0]                       vm_addr;
    logic [1:0]                          vm_wdata;
    logic                                dm_we;

    // table size in use: zero counts as one, clamped to the bucket count and to 31
    always_comb begin
        if (r_table_size == '0) begin
            size = tsbhm_pkg::SIZE_W'(1);
        end else if (PW'(r_table_size) > PW'(MAX_SIZE)) begin
            size = tsbhm_pkg::SIZE_W'(MAX_SIZE);
        end else begin
            size = r_table_size;
        end
    end

    // request key: clamp length, zero bytes past it, pick the last byte
    always_comb begin
        if (i_in.key_len == '0) begin
            in_len = tsbhm_pkg::KEY_LEN_W'(1);
        end else if (i_in.key_len > tsbhm_pkg::KEY_LEN_W'(KEY_BYTES)) begin
            in_len = tsbhm_pkg::KEY_LEN_W'(KEY_BYTES);
        end else begin
            in_len = i_in.key_len;
        end
        in_key  = '0;
        in_last = '0;
        for (int i = 0; i < tsbhm_pkg::MAX_BYTES; i++) begin
            if (tsbhm_pkg::KEY_LEN_W'(i) < in_len) begin
                in_key[i*tsbhm_pkg::BYTE_W +: tsbhm_pkg::BYTE_W] =
                    i_in.key[i*tsbhm_pkg::BYTE_W +: tsbhm_pkg::BYTE_W];
            end
            if (tsbhm_pkg::KEY_LEN_W'(i + 1) == in_len) begin
                in_last = i_in.key[i*tsbhm_pkg::BYTE_W +: tsbhm_pkg::BYTE_W];
            end
        end
    end

    // bucket check: slot 0 first, a free slot takes the key
    always_comb begin
        hit0 = r_vq[0] && (r_row_q.s0.key == r_key) && (r_row_q.s0.key_len == r_len);
        hit1 = r_vq[1] && (r_row_q.s1.key == r_key) && (r_row_q.s1.key_len == r_len);
        sel1  = r_vq[0] && !hit0;
        found = !sel1 || !r_vq[1] || hit1;
        ins   = sel1 ? !r_vq[1] : !r_vq[0];
        if (r_cmd == tsbhm_pkg::CMD_WRITE) begin
            new_val = r_wval;
        end else if (ins) begin
            new_val = '0;
        end else if (sel1) begin
            new_val = r_row_q.s1.value;
        end else begin
            new_val = r_row_q.s0.value;
        end
        new_slot.key     = r_key;
        new_slot.key_len = r_len;
        new_slot.value   = new_val;
        new_row = r_row_q;
        if (sel1) begin
            new_row.s1 = new_slot;
            new_vld    = r_vq | 2'b10;
        end else begin
            new_row.s0 = new_slot;
            new_vld    = r_vq | 2'b01;
        end
        probes_nxt = r_probes + PW'(1);
        if (CW'(r_idx) + CW'(1) == CW'(size)) begin
            idx_inc = '0;
        end else begin
            idx_inc = r_idx + BW'(1);
        end
    end

    always_comb begin
        vm_we    = (r_state == S_CLEAR) || ((r_state == S_CHECK) && found);
        vm_addr  = (r_state == S_CLEAR) ? r_clr : r_idx;
        vm_wdata = (r_state == S_CLEAR) ? 2'b00 : new_vld;
        dm_we    = (r_state == S_CHECK) && found;
    end

    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            r_vmem[vm_addr] <= vm_wdata;
        end
        r_vq <= r_vmem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dmem[r_idx] <= new_row;
        end
        r_row_q <= r_dmem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= tsbhm_pkg::TABLE_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_size <= i_cfg_data;
        end
    end

    tsbhm_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_start),
        .i_dividend (r_mod_byte),
        .i_divisor  (size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_mod_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FINISH) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == BW'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid && !i_cfg_valid) begin
                        r_cmd       <= i_in.command;
                        r_key       <= in_key;
                        r_len       <= in_len;
                        r_wval      <= i_in.write_value;
                        r_last_byte <= in_last;
                        r_mod_byte  <= in_key[tsbhm_pkg::BYTE_W-1:0];
                        r_mod_start <= 1'b1;
                        r_probes    <= '0;
                        r_state     <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_mod_start <= 1'b0;
                    if (mod_done) begin
                        r_idx   <= BW'(mod_rem);
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (found) begin
                        r_res.read_value <= new_val;
                        r_res.inserted   <= ins;
                        r_res.status     <= tsbhm_pkg::STATUS_OK;
                        r_state          <= S_FINISH;
                    end else if (probes_nxt == PW'(size) + PW'(1)) begin
                        r_res.read_value <= '0;
                        r_res.inserted   <= 1'b0;
                        r_res.status     <= tsbhm_pkg::STATUS_FULL;
                        r_state          <= S_FINISH;
                    end else begin
                        r_probes <= probes_nxt;
                        if (r_probes == '0) begin
                            // second bucket comes from the last key byte
                            r_mod_byte  <= r_last_byte;
                            r_mod_start <= 1'b1;
                            r_state     <= S_MOD;
                        end else begin
                            r_idx   <= idx_inc;
                            r_state <= S_READ;
                        end
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a pending config write goes ahead of a waiting request
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = (r_state == S_IDLE);

endmodule

/* rtl/core/tsbhm_mod.sv */
// bit-serial remainder unit: one quotient bit per cycle over an 8-bit dividend
module tsbhm_mod (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [tsbhm_pkg::BYTE_W-1:0]      i_dividend,
    input  logic [tsbhm_pkg::SIZE_W-1:0]      i_divisor,
    output logic                              o_done,
    output logic [tsbhm_pkg::SIZE_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(tsbhm_pkg::BYTE_W);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_W-1:0]               r_cnt;
    logic [tsbhm_pkg::BYTE_W-1:0]   r_div;
    logic [tsbhm_pkg::SIZE_W-1:0]   r_rem;

    logic [tsbhm_pkg::SIZE_W:0]     rem_sh;
    logic [tsbhm_pkg::SIZE_W:0]     divisor_ext;
    logic [tsbhm_pkg::SIZE_W:0]     rem_sub;

    assign rem_sh      = {r_rem, r_div[tsbhm_pkg::BYTE_W-1]};
    assign divisor_ext = {1'b0, i_divisor};
    assign rem_sub     = rem_sh - divisor_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(tsbhm_pkg::BYTE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    // remainder stays below the divisor, so the shifted value is below twice it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= {r_div[tsbhm_pkg::BYTE_W-2:0], 1'b0};
            if (rem_sh >= divisor_ext) begin
                r_rem <= rem_sub[tsbhm_pkg::SIZE_W-1:0];
            end else begin
                r_rem <= rem_sh[tsbhm_pkg::SIZE_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* sim/testbench.sv */
// self-checking testbench for the two-slot bucket hash map
`timescale 1ns / 100ps

module testbench;

    localparam int BUCKETS         = 16;
    localparam int KEY_BYTES       = 8;
    localparam int POOL            = 24;
    localparam int N_PHASES        = 13;
    localparam int ITEMS_PER_PHASE = 127;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int MAX_REPORTS     = 100;
    localparam int DRAIN_CYCLES    = 60;

    typedef struct {
        bit                                cfg_en;
        logic [tsbhm_pkg::SIZE_W-1:0]      cfg_val;
        tsbhm_pkg::t_req                   req;
        bit                                fixed;
        tsbhm_pkg::t_resp                  want;
    } t_dir_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    tsbhm_pkg::t_req                   i_in = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    tsbhm_pkg::t_resp                  o_out;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [tsbhm_pkg::SIZE_W-1:0]      i_cfg_data = '0;

    // shadow copy of the bucket store
    logic [tsbhm_pkg::KEY_W-1:0]       shadow_key  [2*BUCKETS];
    logic [tsbhm_pkg::KEY_LEN_W-1:0]   shadow_len  [2*BUCKETS];
    logic [tsbhm_pkg::VALUE_W-1:0]     shadow_val  [2*BUCKETS];
    bit                                shadow_used [2*BUCKETS];
    logic [tsbhm_pkg::SIZE_W-1:0]      shadow_size = tsbhm_pkg::TABLE_SIZE_RESET;

    tsbhm_pkg::t_resp                  pending_resp [$];
    t_dir_row                          dir_rows [$];
    logic [tsbhm_pkg::KEY_W-1:0]       pool_key [POOL];
    logic [tsbhm_pkg::KEY_LEN_W-1:0]   pool_len [POOL];
    logic [tsbhm_pkg::SIZE_W-1:0]      phase_size [N_PHASES] = '{5'd2, 5'd1, 5'd3, 5'd0,
                                           5'd4, 5'd6, 5'd5, 5'd8, 5'd12, 5'd20, 5'd16,
                                           5'd31, 5'd9};
    bit                                steady_in = 1'b0;
    int                                err_cnt = 0;
    int                                cycle_cnt = 0;
    int                                ready_hold = 0;

    two_slot_bucket_hash_map #(
        .BUCKETS   (BUCKETS),
        .KEY_BYTES (KEY_BYTES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // probe the shadow store exactly as the map does and return its answer
    function automatic tsbhm_pkg::t_resp map_access(input tsbhm_pkg::t_req r);
        int                                eff;
        int                                idx;
        int                                probes;
        int                                s;
        int                                e;
        int                                slot;
        bit                                done;
        bit                                ins;
        logic [tsbhm_pkg::KEY_LEN_W-1:0]   len;
        logic [tsbhm_pkg::KEY_W-1:0]       k;
        tsbhm_pkg::t_resp                  res;
        eff  = int'(shadow_size);
        done = 1'b0;
        ins  = 1'b0;
        slot = 0;
        if (eff == 0) eff = 1;
        if (eff > BUCKETS) eff = BUCKETS;
        len = r.key_len;
        if (len == 0) len = tsbhm_pkg::KEY_LEN_W'(1);
        if (len > KEY_BYTES) len = tsbhm_pkg::KEY_LEN_W'(KEY_BYTES);
        k = r.key;
        if (len < 8) k &= (64'd1 << (8 * int'(len))) - 64'd1;
        idx = int'(k[7:0]) % eff;
        for (probes = 0; probes < eff + 1 && !done; probes++) begin
            for (s = 0; s < 2 && !done; s++) begin
                e = 2 * idx + s;
                if (!shadow_used[e]) begin
                    shadow_used[e] = 1'b1;
                    shadow_key[e]  = k;
                    shadow_len[e]  = len;
                    shadow_val[e]  = '0;
                    ins  = 1'b1;
                    done = 1'b1;
                    slot = e;
                end else if (shadow_key[e] == k && shadow_len[e] == len) begin
                    done = 1'b1;
                    slot = e;
                end
            end
            if (!done) begin
                // second bucket comes from the last key byte, then walk linearly
                if (probes == 0)
                    idx = int'((k >> (8 * (int'(len) - 1))) & 64'hFF) % eff;
                else
                    idx = (idx + 1) % eff;
            end
        end
        res = '0;
        if (!done) begin
            res.status = tsbhm_pkg::STATUS_FULL;
        end else begin
            if (r.command == tsbhm_pkg::CMD_WRITE) shadow_val[slot] = r.write_value;
            res.read_value = shadow_val[slot];
            res.inserted   = ins;
            res.status     = tsbhm_pkg::STATUS_OK;
        end
        return res;
    endfunction

    task automatic add_row(input bit cfg_en, input logic [tsbhm_pkg::SIZE_W-1:0] cfg_val,
                           input logic cmd, input logic [tsbhm_pkg::KEY_W-1:0] key,
                           input logic [tsbhm_pkg::KEY_LEN_W-1:0] len,
                           input logic [tsbhm_pkg::VALUE_W-1:0] wval,
                           input bit fixed, input logic [tsbhm_pkg::VALUE_W-1:0] rv,
                           input logic ins, input logic st);
        t_dir_row row;
        row.cfg_en              = cfg_en;
        row.cfg_val             = cfg_val;
        row.req.command         = cmd;
        row.req.key             = key;
        row.req.key_len         = len;
        row.req.write_value     = wval;
        row.fixed               = fixed;
        row.want.read_value     = rv;
        row.want.inserted       = ins;
        row.want.status         = st;
        dir_rows.push_back(row);
    endtask

    task automatic refresh_pool_entry(input int i);
        pool_len[i] = tsbhm_pkg::KEY_LEN_W'($urandom_range(1, KEY_BYTES));
        pool_key[i] = {$urandom, $urandom};
        if (pool_len[i] < 8) pool_key[i] &= (64'd1 << (8 * int'(pool_len[i]))) - 64'd1;
    endtask

    // leaves valid high after the transaction so back-to-back requests need no gap
    task automatic issue_request(input tsbhm_pkg::t_req r, input bit fixed,
                                 input tsbhm_pkg::t_resp want);
        int               gap;
        int               pick;
        tsbhm_pkg::t_resp predicted;
        pick = $urandom_range(0, 99);
        if (steady_in || pick < 70) gap = 0;
        else if (pick < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = map_access(r);
        pending_resp.push_back(fixed ? want : predicted);
    endtask

    // table size only changes with no request in flight
    task automatic write_table_size(input logic [tsbhm_pkg::SIZE_W-1:0] v);
        i_in_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shadow_size = v;
    endtask

    task automatic report_mismatch(input string field,
                                   input logic [tsbhm_pkg::VALUE_W-1:0] want,
                                   input logic [tsbhm_pkg::VALUE_W-1:0] got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
    endtask

    // result side stalls: mostly short, a few long, some long open stretches
    always @(posedge i_clk) begin : out_stall
        int pick;
        int hold;
        pick = $urandom_range(0, 99);
        hold = 0;
        if (ready_hold == 0) begin
            if (pick < 10) begin
                i_out_ready <= 1'b1;
                hold = $urandom_range(100, 300);
            end else if (pick < 65) begin
                i_out_ready <= 1'b1;
                hold = $urandom_range(0, 15);
            end else if (pick < 95) begin
                i_out_ready <= 1'b0;
                hold = $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b0;
                hold = $urandom_range(10, 40);
            end
            ready_hold <= hold;
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge i_clk) begin : result_check
        tsbhm_pkg::t_resp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_resp.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $error("result transaction with no request outstanding: %h", o_out);
            end else begin
                want = pending_resp.pop_front();
                if (o_out.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, o_out.read_value);
                if (o_out.inserted !== want.inserted)
                    report_mismatch("inserted", tsbhm_pkg::VALUE_W'(want.inserted),
                                    tsbhm_pkg::VALUE_W'(o_out.inserted));
                if (o_out.status !== want.status)
                    report_mismatch("status", tsbhm_pkg::VALUE_W'(want.status),
                                    tsbhm_pkg::VALUE_W'(o_out.status));
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        tsbhm_pkg::t_req                   r;
        tsbhm_pkg::t_resp                  none;
        int                                ph;
        int                                n;
        int                                p;
        int                                pick;
        logic [tsbhm_pkg::KEY_W-1:0]       k;
        logic [tsbhm_pkg::KEY_LEN_W-1:0]   l;
        none = '0;
        for (p = 0; p < POOL; p++) refresh_pool_entry(p);

        // reset size 10: first access, extremes, length and padding handling
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_READ, 64'h05, 4'd1, 32'h0,
                1'b1, 32'h0, 1'b1, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_WRITE, 64'h05, 4'd1, 32'h7FFFFFFF,
                1'b1, 32'h7FFFFFFF, 1'b0, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_READ, 64'hFFFF_FFFF_FFFF_FF05, 4'd1, 32'hFFFFFFFF,
                1'b1, 32'h7FFFFFFF, 1'b0, tsbhm_pkg::STATUS_OK);
        // same first byte but longer key lands in slot 1
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_WRITE, 64'h0005, 4'd2, 32'h80000000,
                1'b1, 32'h80000000, 1'b1, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_READ, 64'h05, 4'd0, 32'h0,
                1'b1, 32'h7FFFFFFF, 1'b0, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFFFFFF,
                1'b0, 32'h0, 1'b0, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_READ, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0,
                1'b1, 32'hFFFFFFFF, 1'b0, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_WRITE, 64'h0305, 4'd2, 32'h0,
                1'b0, 32'h0, 1'b0, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_READ, 64'hA700_0000_0000_0305, 4'd9, 32'h0,
                1'b0, 32'h0, 1'b0, tsbhm_pkg::STATUS_OK);
        // one bucket: fill both slots, then full
        add_row(1'b1, 5'd0, tsbhm_pkg::CMD_WRITE, 64'h11, 4'd1, 32'h1,
                1'b1, 32'h1, 1'b1, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_WRITE, 64'h22, 4'd1, 32'h2,
                1'b1, 32'h2, 1'b1, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_READ, 64'h33, 4'd1, 32'h0,
                1'b1, 32'h0, 1'b0, tsbhm_pkg::STATUS_FULL);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_WRITE, 64'h33, 4'd1, 32'h55,
                1'b1, 32'h0, 1'b0, tsbhm_pkg::STATUS_FULL);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_READ, 64'h22, 4'd1, 32'h0,
                1'b1, 32'h2, 1'b0, tsbhm_pkg::STATUS_OK);
        // oversized table size, entries left in place
        add_row(1'b1, 5'd31, tsbhm_pkg::CMD_READ, 64'h05, 4'd1, 32'h0,
                1'b1, 32'h7FFFFFFF, 1'b0, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_READ, 64'h11, 4'd1, 32'h0,
                1'b0, 32'h0, 1'b0, tsbhm_pkg::STATUS_OK);
        add_row(1'b1, 5'd16, tsbhm_pkg::CMD_WRITE, 64'h0F, 4'd1, 32'h12345678,
                1'b0, 32'h0, 1'b0, tsbhm_pkg::STATUS_OK);
        add_row(1'b1, 5'd17, tsbhm_pkg::CMD_READ, 64'h0F, 4'd1, 32'h0,
                1'b0, 32'h0, 1'b0, tsbhm_pkg::STATUS_OK);
        add_row(1'b0, 5'd0, tsbhm_pkg::CMD_WRITE, 64'h00, 4'd1, 32'h7FFFFFFF,
                1'b0, 32'h0, 1'b0, tsbhm_pkg::STATUS_OK);
        add_row(1'b1, 5'd1, tsbhm_pkg::CMD_READ, 64'h77, 4'd1, 32'h0,
                1'b1, 32'h0, 1'b0, tsbhm_pkg::STATUS_FULL);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_en) write_table_size(dir_rows[i].cfg_val);
            issue_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            write_table_size(phase_size[ph]);
            repeat (6) refresh_pool_entry($urandom_range(0, POOL - 1));
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) steady_in = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    // noise: any key, any length code
                    k = {$urandom, $urandom};
                    l = tsbhm_pkg::KEY_LEN_W'($urandom_range(0, 15));
                end else begin
                    p = $urandom_range(0, POOL - 1);
                    k = pool_key[p];
                    l = pool_len[p];
                    // junk beyond the key length must not change the match
                    if (l < 8 && $urandom_range(0, 1) == 1)
                        k |= {$urandom, $urandom} & ~((64'd1 << (8 * int'(l))) - 64'd1);
                    if (l == 8 && $urandom_range(0, 2) == 0)
                        l = tsbhm_pkg::KEY_LEN_W'($urandom_range(9, 15));
                    if (l == 1 && $urandom_range(0, 2) == 0) l = '0;
                end
                r.command = $urandom_range(0, 1) ? tsbhm_pkg::CMD_WRITE : tsbhm_pkg::CMD_READ;
                r.key     = k;
                r.key_len = l;
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       r.write_value = 32'sh7FFFFFFF;
                        1:       r.write_value = 32'sh80000000;
                        2:       r.write_value = '0;
                        default: r.write_value = '1;
                    endcase
                end else begin
                    r.write_value = $urandom;
                end
                issue_request(r, 1'b0, none);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
